>>> hw/rtl/world_to_screen_projection_assert.svh
// ----------------------------------------------------------------------------
// World-to-screen projection: assertion macros
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH

// same-cycle implication
`define WTSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// implication after a fixed number of cycles
`define WTSP_ASSERT_DLY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) else $error(msg);

`endif

>>> hw/rtl/wtsp_pkg.sv
// ----------------------------------------------------------------------------
// wtsp_pkg
// Types, constants and helpers shared by the projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package wtsp_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned WideW     = 64;
  localparam int unsigned SizeW     = 13;
  localparam int unsigned MulW      = SizeW + 15;
  localparam int unsigned IntCells  = 18;
  localparam int unsigned FracCells = MulW;
  localparam int unsigned IntCmpW   = (WideW - 1) + (IntCells - 1);
  localparam int unsigned FracCmpW  = WideW + 1;
  localparam int unsigned ProdW     = (IntCells - 1) + MulW;
  localparam int unsigned TotW      = ProdW + 1;
  localparam int unsigned RatioW    = 48;
  localparam int unsigned PixW      = 49;
  localparam int unsigned AddrW     = 6;
  // prep stage, the cells, product stage, sign stage
  localparam int unsigned RatioLat  = IntCells + FracCells + 3;
  localparam int unsigned SideDepth = RatioLat - 2;
  localparam int unsigned OutLat    = RatioLat + 3;

  localparam logic signed [WideW-1:0]  NearLimit   = 64'sd17179870;
  localparam logic signed [WideW-1:0]  BigMag      = 64'sd35184372088832;
  localparam logic signed [RatioW-1:0] SatMag      = 48'sd1099511627776;
  localparam logic signed [17:0]       BehindScale = 18'sd100000;
  localparam logic signed [PixW-1:0]   HalfQ16     = 49'sd32768;

  typedef enum logic [2:0] {
    RegRow0Lo  = 3'd0,
    RegRow0Hi  = 3'd1,
    RegRow1Lo  = 3'd2,
    RegRow1Hi  = 3'd3,
    RegRow3Lo  = 3'd4,
    RegRow3Hi  = 3'd5,
    RegViewW   = 3'd6,
    RegViewH   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pixel_x;
    logic signed [CoordW-1:0] pixel_y;
    logic                     on_screen;
  } result_t;

  typedef struct packed {
    logic [WideW-1:0] r0_lo;
    logic [WideW-1:0] r0_hi;
    logic [WideW-1:0] r1_lo;
    logic [WideW-1:0] r1_hi;
    logic [WideW-1:0] r3_lo;
    logic [WideW-1:0] r3_hi;
  } matrix_t;

  typedef struct packed {
    logic [WideW-1:0]    rem;
    logic [WideW-2:0]    w;
    logic [IntCells-1:0] qi;
    logic                neg;
  } int_stage_t;

  typedef struct packed {
    logic [WideW-1:0]    rr;
    logic [WideW-1:0]    r;
    logic [WideW-2:0]    w;
    logic [MulW-1:0]     q;
    logic [IntCells-1:0] qi;
    logic                neg;
  } frac_stage_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [PixW-1:0] v);
    if (v > 49'sd2147483647) return 32'sh7fffffff;
    if (v < -49'sd2147483648) return 32'sh80000000;
    return $signed(v[CoordW-1:0]);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wtsp_xform.sv
// ----------------------------------------------------------------------------
// wtsp_xform
// Row-times-point products (one stage) and their sums (one stage).
// ----------------------------------------------------------------------------
`default_nettype none

module wtsp_xform (
  input  logic                    clk_i,
  input  wtsp_pkg::point_t        point_i,
  input  wtsp_pkg::matrix_t       matrix_i,
  output logic signed [63:0]      cx_o,
  output logic signed [63:0]      cy_o,
  output logic signed [63:0]      w_o
);
  import wtsp_pkg::*;

  logic signed [CoordW-1:0] coef  [3][3];
  logic signed [CoordW-1:0] col3  [3];
  logic signed [CoordW-1:0] coord [3];
  logic [WideW-1:0]         lo    [3];
  logic [WideW-1:0]         hi    [3];
  logic signed [WideW-1:0]  prod_q [3][3];
  logic signed [WideW-1:0]  acc_q  [3];

  always_comb begin
    lo[0] = matrix_i.r0_lo;
    hi[0] = matrix_i.r0_hi;
    lo[1] = matrix_i.r1_lo;
    hi[1] = matrix_i.r1_hi;
    lo[2] = matrix_i.r3_lo;
    hi[2] = matrix_i.r3_hi;
    coord[0] = point_i.point_x;
    coord[1] = point_i.point_y;
    coord[2] = point_i.point_z;
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = $signed(lo[r][31:0]);
      coef[r][1] = $signed(lo[r][63:32]);
      coef[r][2] = $signed(hi[r][31:0]);
      col3[r]    = $signed(hi[r][63:32]);
    end
  end

  // Q.36 products, then floor to Q.34 and add column 3 lifted to Q.34
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[r][k] <= coef[r][k] * coord[k];
      end
      acc_q[r] <= (prod_q[r][0] >>> 2) + (prod_q[r][1] >>> 2) + (prod_q[r][2] >>> 2)
                + $signed({{18{col3[r][31]}}, col3[r], 14'b0});
    end
  end

  assign cx_o = acc_q[0];
  assign cy_o = acc_q[1];
  assign w_o  = acc_q[2];

endmodule

`default_nettype wire

>>> hw/rtl/wtsp_int_cell.sv
// ----------------------------------------------------------------------------
// wtsp_int_cell
// One restoring-division step of the integer quotient |c| / w.
// ----------------------------------------------------------------------------
`default_nettype none

module wtsp_int_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic                   clk_i,
  input  wtsp_pkg::int_stage_t   stage_i,
  output wtsp_pkg::int_stage_t   stage_o
);
  import wtsp_pkg::*;

  logic [IntCmpW-1:0] rem_ext;
  logic [IntCmpW-1:0] div_sh;
  logic [IntCmpW-1:0] diff;
  logic               take;
  int_stage_t         stage_d;
  int_stage_t         stage_q;

  always_comb begin
    rem_ext = IntCmpW'(stage_i.rem);
    div_sh  = IntCmpW'(stage_i.w) << Shift;
    take    = rem_ext >= div_sh;
    diff    = rem_ext - div_sh;
    stage_d = stage_i;
    if (take) begin
      stage_d.rem       = diff[WideW-1:0];
      stage_d.qi[Shift] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

>>> hw/rtl/wtsp_frac_cell.sv
// ----------------------------------------------------------------------------
// wtsp_frac_cell
// One step of floor(r * m / w), taking one bit of m, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module wtsp_frac_cell (
  input  logic                   clk_i,
  input  logic                   m_bit_i,
  input  wtsp_pkg::frac_stage_t  stage_i,
  output wtsp_pkg::frac_stage_t  stage_o
);
  import wtsp_pkg::*;

  logic [FracCmpW-1:0] sum;
  logic [FracCmpW-1:0] w1;
  logic [FracCmpW-1:0] w2;
  logic [FracCmpW-1:0] sub1;
  logic [FracCmpW-1:0] sub2;
  logic                ge1;
  logic                ge2;
  frac_stage_t         stage_d;
  frac_stage_t         stage_q;

  // 2*rr + bit*r stays below 3*w, so at most two w come off
  always_comb begin
    sum  = {stage_i.rr, 1'b0} + (m_bit_i ? {1'b0, stage_i.r} : '0);
    w1   = {2'b0, stage_i.w};
    w2   = {1'b0, stage_i.w, 1'b0};
    sub1 = sum - w1;
    sub2 = sum - w2;
    ge1  = sum >= w1;
    ge2  = sum >= w2;
    stage_d = stage_i;
    stage_d.q = {stage_i.q[MulW-2:0], 1'b0} + MulW'({ge2, ge1 & ~ge2});
    if (ge2) begin
      stage_d.rr = sub2[WideW-1:0];
    end else if (ge1) begin
      stage_d.rr = sub1[WideW-1:0];
    end else begin
      stage_d.rr = sum[WideW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

>>> hw/rtl/wtsp_ratio.sv
// ----------------------------------------------------------------------------
// wtsp_ratio
// floor(c * m / w) for w > 0 as a row of division cells, clamped when huge.
// ----------------------------------------------------------------------------
`default_nettype none

module wtsp_ratio (
  input  logic                clk_i,
  input  logic signed [63:0]  c_i,
  input  logic signed [63:0]  w_i,
  input  logic [27:0]         m_i,
  output logic signed [47:0]  t_o
);
  import wtsp_pkg::*;

  int_stage_t  int_s  [IntCells+1];
  frac_stage_t frac_s [FracCells+1];

  logic [ProdW-1:0]          prod_q;
  logic [MulW-1:0]           q_q;
  logic                      nz_q;
  logic                      neg_q;
  logic                      ovf_q;
  logic                      mz_q;
  logic [TotW-1:0]           total;
  logic signed [RatioW-1:0]  t_d;
  logic signed [RatioW-1:0]  t_q;

  // magnitude and sign of c
  always_ff @(posedge clk_i) begin
    int_s[0].rem <= c_i[WideW-1] ? WideW'(-c_i) : WideW'(c_i);
    int_s[0].w   <= w_i[WideW-2:0];
    int_s[0].qi  <= '0;
    int_s[0].neg <= c_i[WideW-1];
  end

  // top cell flags a quotient of 2^17 or more
  for (genvar k = 0; k < IntCells; k++) begin : g_int
    wtsp_int_cell #(
      .Shift (IntCells - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .stage_i (int_s[k]),
      .stage_o (int_s[k+1])
    );
  end

  always_comb begin
    frac_s[0].rr  = '0;
    frac_s[0].r   = int_s[IntCells].rem;
    frac_s[0].w   = int_s[IntCells].w;
    frac_s[0].q   = '0;
    frac_s[0].qi  = int_s[IntCells].qi;
    frac_s[0].neg = int_s[IntCells].neg;
  end

  for (genvar j = 0; j < FracCells; j++) begin : g_frac
    wtsp_frac_cell u_cell (
      .clk_i   (clk_i),
      .m_bit_i (m_i[FracCells-1-j]),
      .stage_i (frac_s[j]),
      .stage_o (frac_s[j+1])
    );
  end

  always_ff @(posedge clk_i) begin
    prod_q <= frac_s[FracCells].qi[IntCells-2:0] * m_i;
    q_q    <= frac_s[FracCells].q;
    nz_q   <= frac_s[FracCells].rr != '0;
    neg_q  <= frac_s[FracCells].neg;
    ovf_q  <= frac_s[FracCells].qi[IntCells-1];
    mz_q   <= m_i == '0;
  end

  always_comb begin
    total = TotW'(prod_q) + TotW'(q_q);
    if (ovf_q && !mz_q) begin
      t_d = neg_q ? -SatMag : SatMag;
    end else if (neg_q) begin
      t_d = -$signed(RatioW'(total)) - $signed(RatioW'(nz_q));
    end else begin
      t_d = $signed(RatioW'(total));
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
  end

  assign t_o = t_q;

endmodule

`default_nettype wire

>>> hw/rtl/world_to_screen_projection.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Perspective projection of Q16.16 world points to Q16.16 screen pixels.
// ----------------------------------------------------------------------------
// channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------
// point in  | start, busy                | point_i (point_t)
// result    | done_o strobe, one cycle   | result_o (result_t)
// config    | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One beat is taken every cycle; busy stays low.
// The pipeline is built around the division row: 18 integer cells and
// 28 fraction cells per coordinate, plus product, sum and output stages.
// Reset clears the valid line and loads the register reset values.
// The receiver cannot stall; results leave on a fixed schedule.
// ----------------------------------------------------------------------------
`default_nettype none
`include "world_to_screen_projection_assert.svh"

module world_to_screen_projection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  wtsp_pkg::point_t   point_i,
  output logic               done_o,
  output wtsp_pkg::result_t  result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import wtsp_pkg::*;

  typedef struct packed {
    logic                     near;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
  } side_t;

  matrix_t                  mat_q;
  logic [SizeW-1:0]         view_w_q;
  logic [SizeW-1:0]         view_h_q;
  logic                     wr_en;
  reg_idx_e                 wr_idx;

  logic signed [WideW-1:0]  cx_s;
  logic signed [WideW-1:0]  cy_s;
  logic signed [WideW-1:0]  w_s;
  logic [MulW-1:0]          mw;
  logic [MulW-1:0]          mh;
  logic signed [RatioW-1:0] t_x;
  logic signed [RatioW-1:0] t_y;

  logic [RatioLat+1:0]      vld_q;
  logic signed [WideW-1:0]  bpx_q;
  logic signed [WideW-1:0]  bpy_q;
  logic [3:0]               big_q;
  logic                     near_a_q;
  side_t                    side_b_q;
  side_t                    line_q [SideDepth];
  side_t                    side_e;

  logic signed [PixW-1:0]   px_full;
  logic signed [PixW-1:0]   py_full;
  logic                     done_q;
  result_t                  result_d;
  result_t                  result_q;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wr_idx = reg_idx_e'(paddr[AddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q    <= '0;
      view_w_q <= 13'd1280;
      view_h_q <= 13'd720;
    end else if (wr_en) begin
      unique case (wr_idx)
        RegRow0Lo: mat_q.r0_lo <= pwdata;
        RegRow0Hi: mat_q.r0_hi <= pwdata;
        RegRow1Lo: mat_q.r1_lo <= pwdata;
        RegRow1Hi: mat_q.r1_hi <= pwdata;
        RegRow3Lo: mat_q.r3_lo <= pwdata;
        RegRow3Hi: mat_q.r3_hi <= pwdata;
        RegViewW:  view_w_q    <= pwdata[SizeW-1:0];
        RegViewH:  view_h_q    <= pwdata[SizeW-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      RegRow0Lo: prdata = mat_q.r0_lo;
      RegRow0Hi: prdata = mat_q.r0_hi;
      RegRow1Lo: prdata = mat_q.r1_lo;
      RegRow1Hi: prdata = mat_q.r1_hi;
      RegRow3Lo: prdata = mat_q.r3_lo;
      RegRow3Hi: prdata = mat_q.r3_hi;
      RegViewW:  prdata = WideW'(view_w_q);
      RegViewH:  prdata = WideW'(view_h_q);
      default:   prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------
  assign busy = 1'b0;
  assign mw   = {view_w_q, 15'b0};
  assign mh   = {view_h_q, 15'b0};

  wtsp_xform u_xform (
    .clk_i    (clk_i),
    .point_i  (point_i),
    .matrix_i (mat_q),
    .cx_o     (cx_s),
    .cy_o     (cy_s),
    .w_o      (w_s)
  );

  wtsp_ratio u_ratio_x (
    .clk_i (clk_i),
    .c_i   (cx_s),
    .w_i   (w_s),
    .m_i   (mw),
    .t_o   (t_x)
  );

  wtsp_ratio u_ratio_y (
    .clk_i (clk_i),
    .c_i   (cy_s),
    .w_i   (w_s),
    .m_i   (mh),
    .t_o   (t_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[RatioLat:0], start & ~busy};
      done_q <= vld_q[RatioLat+1];
    end
  end

  // behind-the-viewer values: clip * 100000 / 2^18, built beside the divider
  always_ff @(posedge clk_i) begin
    bpx_q    <= $signed(cx_s[46:0]) * BehindScale;
    bpy_q    <= $signed(cy_s[46:0]) * BehindScale;
    big_q    <= {cx_s > BigMag, cx_s < -BigMag, cy_s > BigMag, cy_s < -BigMag};
    near_a_q <= w_s < NearLimit;

    side_b_q.near <= near_a_q;
    side_b_q.bx   <= big_q[3] ? 32'sh7fffffff :
                     big_q[2] ? 32'sh80000000 : sat32(PixW'(bpx_q >>> 18));
    side_b_q.by   <= big_q[1] ? 32'sh7fffffff :
                     big_q[0] ? 32'sh80000000 : sat32(PixW'(bpy_q >>> 18));

    line_q[0] <= side_b_q;
    for (int i = 1; i < SideDepth; i++) begin
      line_q[i] <= line_q[i-1];
    end
  end

  assign side_e = line_q[SideDepth-1];

  always_comb begin
    px_full = $signed(PixW'(mw)) + PixW'(t_x) + HalfQ16;
    py_full = $signed(PixW'(mh)) - (PixW'(t_y) + HalfQ16);
    if (side_e.near) begin
      result_d.pixel_x   = side_e.bx;
      result_d.pixel_y   = side_e.by;
      result_d.on_screen = 1'b0;
    end else begin
      result_d.pixel_x   = sat32(px_full);
      result_d.pixel_y   = sat32(py_full);
      result_d.on_screen = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // ---------------- checks ----------------
  `WTSP_ASSERT_DLY(a_beat_gives_result, start && !busy, OutLat, done_o, "beat lost in pipeline")
  `WTSP_ASSERT_IMP(a_result_has_beat, done_o, $past(start && !busy, OutLat), "result without beat")
  `WTSP_ASSERT_IMP(a_visible_matches_w, done_o, result_o.on_screen == ($past(w_s, OutLat - 2) >= NearLimit), "visibility misaligned with w")

endmodule

`default_nettype wire

>>> test/tb_world_to_screen_projection.sv
// ----------------------------------------------------------------------------
// World-to-screen projection testbench
// Drives points through the block under changing matrices and screen sizes,
// predicts each projected pixel or behind-viewer clip value and checks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_world_to_screen_projection;
  import wtsp_pkg::*;

  localparam int LatencyCycles = 60;
  localparam int IdleLimit     = 2000;
  localparam int RandomPoints  = 1250;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  point_t      point_i;
  logic        done_o;
  result_t     result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  world_to_screen_projection DUT (.*);

  // shadow of the block's registers
  logic [63:0] mat_q [6];
  logic [12:0] width_q, height_q;

  result_t pixel_queue[$];
  int      mismatches;
  int      idle_cycles;
  int      send_idle_pct;
  bit      timed_out;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint floor_div4(longint v);
    return v >>> 2;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint row_dot(logic [63:0] lo, logic [63:0] hi, point_t p);
    longint acc;
    acc = floor_div4(sx32(lo[31:0]) * sx32(p.point_x));
    acc += floor_div4(sx32(lo[63:32]) * sx32(p.point_y));
    acc += floor_div4(sx32(hi[31:0]) * sx32(p.point_z));
    acc += sx32(hi[63:32]) * 64'sd16384;
    return acc;
  endfunction

  function automatic longint behind_value(longint c);
    if (c > 64'sd35184372088832) return 64'sd2147483647;
    if (c < -64'sd35184372088832) return -64'sd2147483648;
    return clamp32((c * 64'sd100000) >>> 18);
  endfunction

  // floor(c*m/w), exact in 128 bits, with the block's clamp on the integer part
  function automatic longint ratio_floor(longint c, longint w, longint m);
    logic signed [127:0] num, q;
    longint mag;
    if (m == 0) return 0;
    mag = (c < 0) ? -c : c;
    if ((mag / w) >= (64'sd1 <<< 17)) return (c < 0) ? -64'sd1099511627776
                                                      : 64'sd1099511627776;
    num = 128'(signed'(c)) * 128'(signed'(m));
    q = num / 128'(signed'(w));
    if ((num % 128'(signed'(w))) != 0 && num < 0) q = q - 1;
    return longint'(q);
  endfunction

  function automatic result_t project_point(point_t p);
    result_t r;
    longint cx, cy, w, mw, mh;
    cx = row_dot(mat_q[0], mat_q[1], p);
    cy = row_dot(mat_q[2], mat_q[3], p);
    w  = row_dot(mat_q[4], mat_q[5], p);
    if (w < 64'sd17179870) begin
      r.pixel_x = 32'(behind_value(cx));
      r.pixel_y = 32'(behind_value(cy));
      r.on_screen = 1'b0;
    end else begin
      mw = longint'(width_q) <<< 15;
      mh = longint'(height_q) <<< 15;
      r.pixel_x = 32'(clamp32(mw + ratio_floor(cx, w, mw) + 64'sd32768));
      r.pixel_y = 32'(clamp32(mh - (ratio_floor(cy, w, mh) + 64'sd32768)));
      r.on_screen = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      idle_cycles <= 0;
      if (pixel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", result_o);
      end else begin
        result_t exp_r;
        exp_r = pixel_queue.pop_front();
        if (exp_r.pixel_x !== result_o.pixel_x || exp_r.pixel_y !== result_o.pixel_y ||
            exp_r.on_screen !== result_o.on_screen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d vis=%0b, got x=%0d y=%0d vis=%0b",
                     exp_r.pixel_x, exp_r.pixel_y, exp_r.on_screen,
                     result_o.pixel_x, result_o.pixel_y, result_o.on_screen);
        end
      end
    end else if (start && !busy) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 6'(int'(idx) * 8); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (int'(idx) < 6) mat_q[int'(idx)] = val;
    else if (idx == RegViewW) width_q = val[12:0];
    else height_q = val[12:0];
  endtask

  // waits for outstanding results, then the tail of the pipeline
  task automatic drain();
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  // sends one point with a given expectation; start stays high across
  // back-to-back beats
  task automatic send_beat(point_t p, result_t exp_r, bit keep_high);
    start   <= 1'b1;
    point_i <= p;
    do @(posedge clk_i); while (busy);
    pixel_queue.push_back(exp_r);
    if (!keep_high) start <= 1'b0;
  endtask

  task automatic send_point(point_t p, bit keep_high);
    send_beat(p, project_point(p), keep_high);
  endtask

  function automatic logic [63:0] rand_pair();
    return {$urandom(), $urandom()};
  endfunction

  // coefficient in Q12.20 within +-span
  function automatic logic [31:0] rand_coef(int unsigned span);
    return 32'($signed($urandom_range(2 * span, 0)) - $signed(span));
  endfunction

  function automatic point_t rand_point(int mode);
    point_t p;
    if (mode == 0) begin
      p.point_x = $urandom(); p.point_y = $urandom(); p.point_z = $urandom();
    end else begin
      p.point_x = 32'($signed($urandom_range(2 << 22, 0)) - (1 << 22));
      p.point_y = 32'($signed($urandom_range(2 << 22, 0)) - (1 << 22));
      p.point_z = 32'($signed($urandom_range(2 << 22, 0)) - (1 << 22));
    end
    return p;
  endfunction

  // a camera-like matrix: w mostly positive so most points land in front
  task automatic load_camera(logic [12:0] w_px, logic [12:0] h_px);
    write_reg(RegRow0Lo, {rand_coef(1 << 21), rand_coef(1 << 21)});
    write_reg(RegRow0Hi, {rand_coef(1 << 24), rand_coef(1 << 21)});
    write_reg(RegRow1Lo, {rand_coef(1 << 21), rand_coef(1 << 21)});
    write_reg(RegRow1Hi, {rand_coef(1 << 24), rand_coef(1 << 21)});
    write_reg(RegRow3Lo, {rand_coef(1 << 18), rand_coef(1 << 18)});
    write_reg(RegRow3Hi, {32'($urandom_range(1 << 26, 1 << 20)), rand_coef(1 << 19)});
    write_reg(RegViewW, 64'(w_px));
    write_reg(RegViewH, 64'(h_px));
  endtask

  typedef struct {
    point_t  pt;
    bit      typed;
    result_t want;
  } vec_t;

  initial begin
    vec_t    dir_rows[$];
    vec_t    v;
    point_t  p;
    int      phase, n, seg;
    logic [12:0] sizes_w [4];
    logic [12:0] sizes_h [4];

    rst_ni = 1'b0; start = 1'b0; point_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0; idle_cycles = 0; timed_out = 1'b0;
    for (int i = 0; i < 6; i++) mat_q[i] = '0;
    width_q = 13'd1280; height_q = 13'd720;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: zero matrix, w = 0 so every point is behind with zero clip
    v.typed = 1'b1; v.want = '{pixel_x: 32'sd0, pixel_y: 32'sd0, on_screen: 1'b0};
    v.pt = '{point_x: 32'sh7fffffff, point_y: 32'sh80000000, point_z: 32'sd0};
    dir_rows.push_back(v);
    v.pt = '{point_x: 32'sh80000000, point_y: 32'sh7fffffff, point_z: 32'shffffffff};
    dir_rows.push_back(v);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].pt,
                dir_rows[i].typed ? dir_rows[i].want : project_point(dir_rows[i].pt),
                i != dir_rows.size() - 1);
    drain();

    // identity-ish camera, w = 1.0 from column 3; extremes, near limit,
    // saturation both ways and zero sizes
    write_reg(RegRow0Lo, {32'sd0, 32'sd1048576});
    write_reg(RegRow0Hi, 64'd0);
    write_reg(RegRow1Lo, {32'sd1048576, 32'sd0});
    write_reg(RegRow1Hi, 64'd0);
    write_reg(RegRow3Lo, 64'd0);
    write_reg(RegRow3Hi, {32'sd1048576, 32'sh80000000});
    dir_rows.delete();
    v.typed = 1'b0;
    v.pt = '{point_x: 32'sd0, point_y: 32'sd0, point_z: 32'sd0}; dir_rows.push_back(v);
    v.pt = '{point_x: 32'sh7fffffff, point_y: 32'sh80000000, point_z: 32'sd0};
    dir_rows.push_back(v);
    v.pt = '{point_x: 32'sh80000000, point_y: 32'sh7fffffff, point_z: 32'sd0};
    dir_rows.push_back(v);
    // z column is -2048; z = 1/2048 and 1/2048 - tiny put w either side of the near limit
    v.pt = '{point_x: 32'sd65536, point_y: 32'sd65536, point_z: 32'sd0}; dir_rows.push_back(v);
    v.pt = '{point_x: 32'sd65536, point_y: 32'sd65536, point_z: 32'sd32};
    dir_rows.push_back(v);
    v.pt = '{point_x: 32'sd65536, point_y: 32'sd65536, point_z: 32'sd31};
    dir_rows.push_back(v);
    v.pt = '{point_x: 32'sd65536, point_y: 32'sd65536, point_z: 32'sh7fffffff};
    dir_rows.push_back(v);
    v.pt = '{point_x: 32'shffffffff, point_y: 32'sd1, point_z: 32'sh80000000};
    dir_rows.push_back(v);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].pt,
                dir_rows[i].typed ? dir_rows[i].want : project_point(dir_rows[i].pt),
                i != dir_rows.size() - 1);
    drain();

    write_reg(RegViewW, 64'd0);
    write_reg(RegViewH, 64'd4096);
    send_point('{point_x: 32'sd12345, point_y: -32'sd98765, point_z: 32'sd0}, 1'b1);
    send_point('{point_x: 32'sh7fffffff, point_y: 32'sh7fffffff, point_z: 32'sd0}, 1'b0);
    drain();
    write_reg(RegViewW, 64'h1fff);
    write_reg(RegViewH, 64'd1);
    send_point('{point_x: 32'sh7fffffff, point_y: 32'sh80000000, point_z: 32'sd0}, 1'b1);
    send_point('{point_x: 32'sd1, point_y: -32'sd1, point_z: 32'sd0}, 1'b0);
    drain();

    // all ones in every matrix register: w column 3 negative, but the products put the point in front
    for (int r = 0; r < 6; r++) write_reg(reg_idx_e'(r), 64'hffff_ffff_ffff_ffff);
    send_point('{point_x: 32'sh80000000, point_y: 32'sh80000000, point_z: 32'sh80000000},
               1'b0);
    drain();

    // random part: three idling phases, several camera/size settings each
    sizes_w = '{13'd1, 13'd1280, 13'd4096, 13'd640};
    sizes_h = '{13'd4096, 13'd720, 13'd1, 13'd480};
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 82 : 0;
      for (seg = 0; seg < 4; seg++) begin
        if (seg == 3) begin
          for (int r = 0; r < 6; r++) write_reg(reg_idx_e'(r), rand_pair());
          write_reg(RegViewW, 64'($urandom_range(8191, 0)));
          write_reg(RegViewH, 64'($urandom_range(8191, 0)));
        end else begin
          load_camera(sizes_w[(seg + phase) % 4], sizes_h[(seg + phase) % 4]);
        end
        n = RandomPoints / 12;
        for (int k = 0; k < n; k++) begin
          // each cycle idles with the phase's odds
          while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge clk_i);
          end
          p = rand_point(($urandom_range(9, 0) < 2) ? 0 : 1);
          send_point(p, k != n - 1);
        end
        drain();
      end
    end

    drain();
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
